// ===== design/rgbhsv_pkg.sv =====
// rgbhsv_pkg: types and constants shared by the rgb to hsv converter
// holds the divider lane and stage payload types and the cell step function
// no dependencies
package rgbhsv_pkg;

   // quotient bits, one divider cell per bit
   localparam int QBITS    = 17;
   // divisor width (twice an 8-bit value)
   localparam int DBITS    = 9;
   // full dividend width: partial remainder on top of the quotient bits
   localparam int XBITS    = DBITS + QBITS;
   localparam int HUE_W    = 15;
   localparam int SAT_W    = 17;
   localparam int VAL_W    = 8;
   localparam int RSP_W    = 40;
   localparam int REQ_W    = 24;

   // hue sextant in 1/64 degree and the upper ends of the result ranges
   localparam logic [11:0]      HUE_SEXTANT = 12'd3840;
   localparam logic [HUE_W-1:0] HUE_MAX     = 15'd23039;
   localparam logic [SAT_W-1:0] SAT_MAX     = 17'd65536;

   // sextant offsets picked by the channel that holds the maximum
   localparam logic [2:0] BASE_RED  = 3'd0;
   localparam logic [2:0] BASE_WRAP = 3'd6;
   localparam logic [2:0] BASE_GRN  = 3'd2;
   localparam logic [2:0] BASE_BLU  = 3'd4;

   // one restoring divider lane: remainder, divisor, dividend bits with
   // quotient bits shifted in from the bottom
   typedef struct packed {
      logic [DBITS-1:0] rem;
      logic [DBITS-1:0] dvs;
      logic [QBITS-1:0] nq;
   } lane_type;

   // payload moving down the chain
   typedef struct packed {
      logic [VAL_W-1:0] value;
      lane_type         hue;
      lane_type         sat;
   } stage_type;

   // one quotient bit of restoring division
   function automatic lane_type div_step(lane_type lane);
      logic [DBITS:0] trial;
      logic [DBITS:0] diff;
      logic           ge;
      lane_type       nxt;
      trial   = {lane.rem, lane.nq[QBITS-1]};
      diff    = trial - {1'b0, lane.dvs};
      ge      = (trial >= {1'b0, lane.dvs});
      nxt.dvs = lane.dvs;
      nxt.rem = ge ? diff[DBITS-1:0] : trial[DBITS-1:0];
      nxt.nq  = {lane.nq[QBITS-2:0], ge};
      return nxt;
   endfunction

endpackage

// ===== design/rgb_to_hsv_converter.sv =====
// rgb_to_hsv_converter: pixel rgb to hsv, one request per clock unless stalled
// path: an accepted request goes through the setup stage, 17 divider cells
// each giving one quotient bit of hue and saturation, and the output register
// throughput: one request per cycle when not stalled, set by the divider chain
// reset: synchronous active-high reset clears all valid flags, payload is not reset
// depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_div_cell, rgbhsv_out_buf
module rgb_to_hsv_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hue[14:0], saturation[31:15], value[39:32]
);

   localparam int N = rgbhsv_pkg::QBITS;

   logic                         en;
   logic                         chain_valid [N+1];
   rgbhsv_pkg::stage_type        chain_data  [N+1];
   logic [rgbhsv_pkg::RSP_W-1:0] result;

   assign req_tready = en;

   // setup stage
   rgbhsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < N; i++) begin : g_cell
      rgbhsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // pack the finished quotients
   assign result = {chain_data[N].value,
                    chain_data[N].sat.nq[rgbhsv_pkg::SAT_W-1:0],
                    chain_data[N].hue.nq[rgbhsv_pkg::HUE_W-1:0]};

   rgbhsv_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[N]),
      .in_data    (result),
      .en         (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // input only stalls while a response is waiting
   a_stall_has_rsp : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no response pending");

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] <= rgbhsv_pkg::HUE_MAX)
      else $error("hue out of range");

   a_sat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:15] <= rgbhsv_pkg::SAT_MAX)
      else $error("saturation out of range");

   // black pixel gives zero hue and saturation
   a_black : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39:32] == 8'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("black pixel with nonzero hue or saturation");

endmodule

// ===== design/rgbhsv_prep.sv =====
// rgbhsv_prep: first stage, finds max, min and delta and sets up both dividers
// depends on rgbhsv_pkg
module rgbhsv_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [7:0]            red,
   input  logic [7:0]            green,
   input  logic [7:0]            blue,
   output logic                  out_valid,
   output rgbhsv_pkg::stage_type out_data
);

   logic                   valid_ff;
   logic                   valid_in;
   rgbhsv_pkg::stage_type  data_ff;
   rgbhsv_pkg::stage_type  data_in;

   logic [7:0]  mx;
   logic [7:0]  mn;
   logic [7:0]  delta;
   logic [2:0]  base;
   logic [9:0]  diff;
   logic [10:0] bd;
   logic [11:0] sum_s;
   logic [22:0] total;
   logic [rgbhsv_pkg::XBITS-1:0] x_hue;
   logic [rgbhsv_pkg::XBITS-1:0] x_sat;

   // max, min and delta of the three channels
   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
   end

   // hue numerator in delta units: base*delta + signed channel difference
   always_comb begin
      if (mx == red) begin
         diff = {2'b00, green} - {2'b00, blue};
         base = (green >= blue) ? rgbhsv_pkg::BASE_RED : rgbhsv_pkg::BASE_WRAP;
      end else if (mx == green) begin
         diff = {2'b00, blue} - {2'b00, red};
         base = rgbhsv_pkg::BASE_GRN;
      end else begin
         diff = {2'b00, red} - {2'b00, green};
         base = rgbhsv_pkg::BASE_BLU;
      end
      bd    = {8'd0, base} * {3'd0, delta};
      sum_s = {1'b0, bd} + {{2{diff[9]}}, diff};
      total = {12'd0, sum_s[10:0]} * {11'd0, rgbhsv_pkg::HUE_SEXTANT};
   end

   // rounded dividends (2n + d) over divisors 2d; zero cases divide 0 by 2
   always_comb begin
      x_sat = {1'b0, delta, 17'd0} + {18'd0, mx};
      x_hue = {1'b0, total, 1'b0} + {18'd0, delta};
      data_in.value = mx;
      if (mx != 8'd0) begin
         data_in.sat.dvs = {mx, 1'b0};
         data_in.sat.rem = x_sat[rgbhsv_pkg::XBITS-1:rgbhsv_pkg::QBITS];
         data_in.sat.nq  = x_sat[rgbhsv_pkg::QBITS-1:0];
      end else begin
         data_in.sat.dvs = 9'd2;
         data_in.sat.rem = '0;
         data_in.sat.nq  = '0;
      end
      if (delta != 8'd0) begin
         data_in.hue.dvs = {delta, 1'b0};
         data_in.hue.rem = x_hue[rgbhsv_pkg::XBITS-1:rgbhsv_pkg::QBITS];
         data_in.hue.nq  = x_hue[rgbhsv_pkg::QBITS-1:0];
      end else begin
         data_in.hue.dvs = 9'd2;
         data_in.hue.rem = '0;
         data_in.hue.nq  = '0;
      end
      valid_in = in_valid;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/rgbhsv_div_cell.sv =====
// rgbhsv_div_cell: one cell of the divider chain, one quotient bit per lane
// depends on rgbhsv_pkg
module rgbhsv_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rgbhsv_pkg::stage_type in_data,
   output logic                  out_valid,
   output rgbhsv_pkg::stage_type out_data
);

   logic                  valid_ff;
   rgbhsv_pkg::stage_type data_ff;
   rgbhsv_pkg::stage_type data_in;

   // one step on both lanes, value rides along
   always_comb begin
      data_in.value = in_data.value;
      data_in.hue   = rgbhsv_pkg::div_step(in_data.hue);
      data_in.sat   = rgbhsv_pkg::div_step(in_data.sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/rgbhsv_out_buf.sv =====
// rgbhsv_out_buf: output register with a one-entry skid stage
// depends on rgbhsv_pkg
module rgbhsv_out_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rgbhsv_pkg::RSP_W-1:0]  in_data,
   output logic                          en,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rgbhsv_pkg::RSP_W-1:0]  rsp_tdata
);

   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [rgbhsv_pkg::RSP_W-1:0] out_data_ff;
   logic [rgbhsv_pkg::RSP_W-1:0] out_data_in;
   logic                         skid_valid_ff;
   logic                         skid_valid_in;
   logic [rgbhsv_pkg::RSP_W-1:0] skid_data_ff;
   logic [rgbhsv_pkg::RSP_W-1:0] skid_data_in;
   logic                         take;

   // chain moves while the skid entry is free
   assign en   = !skid_valid_ff;
   assign take = in_valid && en;

   // refill the output from skid first, then from the chain
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_data_in  = in_data;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
